// File: design/i2cms_pkg.sv
// Shared types and codes for the I2C master transfer sequencer.
// Used by i2cms_core and i2c_master_transfer_sequencer; depends on nothing.
package i2cms_pkg;

   // Item kinds on the request channel.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_EVENT = 1'b1;

   // Peripheral event codes.
   typedef enum logic [2:0] {
      EV_MODE_SELECT  = 3'd0,
      EV_TX_SELECTED  = 3'd1,
      EV_RX_SELECTED  = 3'd2,
      EV_TRANSMITTING = 3'd3,
      EV_TRANSMITTED  = 3'd4,
      EV_RECEIVED     = 3'd5,
      EV_RECEIVED_BTF = 3'd6,
      EV_UNKNOWN      = 3'd7
   } event_type;

   // Transfer status.
   typedef enum logic [1:0] {
      STATUS_IDLE  = 2'd0,
      STATUS_BUSY  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   // Enable/disable control codes.
   localparam logic [1:0] CTL_NONE = 2'd0;
   localparam logic [1:0] CTL_ON   = 2'd1;
   localparam logic [1:0] CTL_OFF  = 2'd2;

   // Small receive-length thresholds.
   localparam int RX_ONE   = 1;
   localparam int RX_TWO   = 2;
   localparam int RX_THREE = 3;

   // Request word.
   typedef struct packed {
      logic       func;
      logic [6:0] target_address;
      logic [7:0] tx_length;
      logic [7:0] rx_length;
      logic [2:0] event_code;
      logic [7:0] next_tx_byte;
      logic [7:0] rx_byte;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [7:0] write_data;
      logic       write_strobe;
      logic       start_request;
      logic       stop_request;
      logic [1:0] ack_control;
      logic       pos_set;
      logic [1:0] buffer_irq_control;
      logic [1:0] event_irq_control;
      logic [7:0] received_byte;
      logic       received_strobe;
      logic [1:0] status;
   } rsp_type;

endpackage

// File: design/i2cms_core.sv
// Decision logic of the I2C master transfer sequencer: one request word and
// the current transfer state give the response word and the next state.
// Depends on i2cms_pkg.
module i2cms_core #(
   parameter int MAX_LENGTH = 255,
   parameter int LEN_W      = 8
) (
   input  i2cms_pkg::req_type    req,
   input  i2cms_pkg::status_type status_cur,
   input  logic [6:0]            addr_cur,
   input  logic [LEN_W-1:0]      tx_cur,
   input  logic [LEN_W-1:0]      rx_exp_cur,
   input  logic [LEN_W-1:0]      rx_done_cur,
   output i2cms_pkg::rsp_type    rsp,
   output i2cms_pkg::status_type status_nxt,
   output logic [6:0]            addr_nxt,
   output logic [LEN_W-1:0]      tx_nxt,
   output logic [LEN_W-1:0]      rx_exp_nxt,
   output logic [LEN_W-1:0]      rx_done_nxt
);
   import i2cms_pkg::*;

   localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_LENGTH);
   localparam logic [LEN_W-1:0] L1    = LEN_W'(RX_ONE);
   localparam logic [LEN_W-1:0] L2    = LEN_W'(RX_TWO);
   localparam logic [LEN_W-1:0] L3    = LEN_W'(RX_THREE);

   logic [16:0]      tx_wide;
   logic [16:0]      rx_wide;
   logic [LEN_W-1:0] tx_clamped;
   logic [LEN_W-1:0] rx_clamped;
   logic             hit_less3;
   logic             hit_less2;
   logic             hit_less1;
   logic             tx_some;

   // Clamp the requested lengths to the largest supported transfer.
   assign tx_wide    = 17'(req.tx_length);
   assign rx_wide    = 17'(req.rx_length);
   assign tx_clamped = (tx_wide > 17'(MAX_LENGTH)) ? MAX_L : LEN_W'(tx_wide);
   assign rx_clamped = (rx_wide > 17'(MAX_LENGTH)) ? MAX_L : LEN_W'(rx_wide);

   // Receive position tests, guarded so that the subtraction cannot wrap.
   assign hit_less3 = (rx_exp_cur >= L3) && (rx_done_cur == rx_exp_cur - L3);
   assign hit_less2 = (rx_exp_cur >= L2) && (rx_done_cur == rx_exp_cur - L2);
   assign hit_less1 = (rx_exp_cur >= L1) && (rx_done_cur == rx_exp_cur - L1);
   assign tx_some   = (tx_cur != '0);

   always_comb begin
      rsp         = '0;
      status_nxt  = status_cur;
      addr_nxt    = addr_cur;
      tx_nxt      = tx_cur;
      rx_exp_nxt  = rx_exp_cur;
      rx_done_nxt = rx_done_cur;

      if (req.func == FUNC_START) begin
         // Latch a new transfer and request START.
         addr_nxt              = req.target_address;
         tx_nxt                = tx_clamped;
         rx_exp_nxt            = rx_clamped;
         rx_done_nxt           = '0;
         status_nxt            = STATUS_BUSY;
         rsp.start_request     = 1'b1;
         rsp.event_irq_control = CTL_ON;
      end else if (status_cur == STATUS_BUSY) begin
         case (event_type'(req.event_code))
            EV_MODE_SELECT: begin
               if (tx_some) begin
                  rsp.write_data   = {addr_cur, 1'b0};
                  rsp.write_strobe = 1'b1;
               end else if (rx_exp_cur != '0) begin
                  rsp.write_data   = {addr_cur, 1'b1};
                  rsp.write_strobe = 1'b1;
               end
            end
            EV_TX_SELECTED: begin
               rsp.buffer_irq_control = CTL_ON;
               if (tx_some) begin
                  tx_nxt           = tx_cur - L1;
                  rsp.write_data   = req.next_tx_byte;
                  rsp.write_strobe = 1'b1;
               end
            end
            EV_RX_SELECTED: begin
               if (rx_exp_cur < L3) begin
                  rsp.ack_control = CTL_OFF;
                  rsp.pos_set     = (rx_exp_cur == L2);
               end else begin
                  rsp.ack_control = CTL_ON;
               end
               rsp.buffer_irq_control = CTL_ON;
            end
            EV_TRANSMITTING: begin
               if (tx_some) begin
                  if (tx_cur == L1 && rx_exp_cur == '0) begin
                     rsp.buffer_irq_control = CTL_OFF;
                  end
                  tx_nxt           = tx_cur - L1;
                  rsp.write_data   = req.next_tx_byte;
                  rsp.write_strobe = 1'b1;
               end else begin
                  rsp.buffer_irq_control = CTL_OFF;
               end
            end
            EV_TRANSMITTED: begin
               if (tx_some) begin
                  if (tx_cur == L1) begin
                     rsp.buffer_irq_control = CTL_OFF;
                  end
                  tx_nxt           = tx_cur - L1;
                  rsp.write_data   = req.next_tx_byte;
                  rsp.write_strobe = 1'b1;
               end else if (rx_exp_cur != '0) begin
                  // Switch to reading with a repeated START.
                  rsp.start_request = 1'b1;
               end else begin
                  rsp.buffer_irq_control = CTL_OFF;
                  rsp.event_irq_control  = CTL_OFF;
                  rsp.stop_request       = 1'b1;
                  status_nxt             = STATUS_IDLE;
               end
            end
            EV_RECEIVED, EV_RECEIVED_BTF: begin
               if (req.event_code == EV_RECEIVED_BTF && hit_less3) begin
                  rsp.ack_control = CTL_OFF;
               end else if (hit_less2) begin
                  rsp.ack_control  = CTL_OFF;
                  rsp.stop_request = 1'b1;
               end else if (hit_less1) begin
                  rsp.event_irq_control  = CTL_OFF;
                  rsp.buffer_irq_control = CTL_OFF;
                  status_nxt             = STATUS_IDLE;
               end
               rsp.received_byte   = req.rx_byte;
               rsp.received_strobe = 1'b1;
               if (rx_done_cur < MAX_L) begin
                  rx_done_nxt = rx_done_cur + L1;
               end
            end
            default: begin
               // Unknown event: shut interrupts off and hold the error.
               rsp.event_irq_control  = CTL_OFF;
               rsp.buffer_irq_control = CTL_OFF;
               status_nxt             = STATUS_ERROR;
            end
         endcase
      end

      rsp.status = status_nxt;
   end

endmodule

// File: design/i2c_master_transfer_sequencer.sv
// I2C master write-then-read transfer sequencer, top level.
// Request channel carries start words and peripheral event words; the
// response channel returns one command word for each request word.
// A start word latches the target address and the clamped transmit and
// receive lengths, requests START and marks the transfer busy. Event words
// give the address byte, data bytes, repeated START, STOP, ACK/POS and
// interrupt-enable commands, hand received bytes on and report status.
// Events arriving while the transfer is not busy return only the status.
// The response word is registered at the edge that accepts the request.
// Throughput is one word per cycle; the decision is
// a single pass of logic from the request port into the response register.
// When the receiver stalls, the response register holds its word and
// req_stall rises, so a new word is taken only when the held one leaves
// in the same cycle. Reset clears the response valid flag and returns the
// transfer to idle with zero address and counts.
// Depends on i2cms_pkg and i2cms_core.
module i2c_master_transfer_sequencer #(
   parameter int MAX_LENGTH = 255
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  i2cms_pkg::req_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output i2cms_pkg::rsp_type rsp_word
);
   import i2cms_pkg::*;

   localparam int LEN_W = $clog2(MAX_LENGTH + 1);

   status_type       status_ff, status_in;
   logic [6:0]       addr_ff, addr_in;
   logic [LEN_W-1:0] tx_ff, tx_in;
   logic [LEN_W-1:0] rx_exp_ff, rx_exp_in;
   logic [LEN_W-1:0] rx_done_ff, rx_done_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_word_ff, rsp_word_in;
   rsp_type          core_rsp;
   logic             req_take;

   // Decision logic for one word.
   i2cms_core #(
      .MAX_LENGTH (MAX_LENGTH),
      .LEN_W      (LEN_W)
   ) u_core (
      .req         (req_word),
      .status_cur  (status_ff),
      .addr_cur    (addr_ff),
      .tx_cur      (tx_ff),
      .rx_exp_cur  (rx_exp_ff),
      .rx_done_cur (rx_done_ff),
      .rsp         (core_rsp),
      .status_nxt  (status_in),
      .addr_nxt    (addr_in),
      .tx_nxt      (tx_in),
      .rx_exp_nxt  (rx_exp_in),
      .rx_done_nxt (rx_done_in)
   );

   // Stall only while a held response cannot leave.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   // Response register control.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = core_rsp;
      end
   end

   // Transfer state and response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= STATUS_IDLE;
         addr_ff      <= '0;
         tx_ff        <= '0;
         rx_exp_ff    <= '0;
         rx_done_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            status_ff  <= status_in;
            addr_ff    <= addr_in;
            tx_ff      <= tx_in;
            rx_exp_ff  <= rx_exp_in;
            rx_done_ff <= rx_done_in;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
